// ===== rtl/core/ast_pkg.sv =====
// Shared types, constants and per-stage datapath functions for the
// accelerometer scale-and-tilt pipeline. No dependencies.
package ast_pkg;

  localparam int CORDIC_STAGES_DEF = 16;

  // Register indexes and reset value
  localparam logic RegRangeSelect = 1'b0;
  localparam logic [1:0] RangeReset = 2'd2;

  // 9.80665 in Q16
  localparam logic signed [33:0] GRAVITY_Q16 = 34'sd642689;
  localparam logic signed [26:0] Z180 = 27'sd11796480;
  localparam logic signed [26:0] PITCH_LIMIT = 27'sd46080;
  localparam logic signed [26:0] ROLL_LIMIT = 27'sd23040;

  // Stage map
  localparam int ST_MUL = 0;
  localparam int ST_ROUND = 1;
  localparam int ST_SQUARE = 2;
  localparam int ST_SUM = 3;
  localparam int ST_SQRT = 4;
  localparam int HSQ_ITERS = 24;
  localparam int MSQ_ITERS = 17;
  localparam int ST_FIN = ST_SQRT + HSQ_ITERS;
  localparam int ST_ROLL = ST_FIN + 1;

  typedef struct packed {
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
    logic signed [33:0] px;
    logic signed [33:0] py;
    logic signed [33:0] pz;
    logic signed [16:0] ax;
    logic signed [16:0] ay;
    logic signed [16:0] az;
    logic [31:0] sqx;
    logic [31:0] sqy;
    logic [31:0] sqz;
    logic [48:0] hrem;
    logic [48:0] hr;
    logic [33:0] mrem;
    logic [33:0] mr;
    logic signed [26:0] cx;
    logic signed [26:0] cy;
    logic signed [26:0] cz;
    logic czero;
    logic signed [26:0] rx;
    logic signed [26:0] ry;
    logic signed [26:0] rz;
    logic rzero;
    logic signed [16:0] pitch;
    logic signed [15:0] roll;
  } item_t;

  function automatic logic signed [26:0] atan_q16(int j);
    logic signed [26:0] v;
    case (j)
      0: v = 27'sd2949120;
      1: v = 27'sd1740967;
      2: v = 27'sd919879;
      3: v = 27'sd466945;
      4: v = 27'sd234379;
      5: v = 27'sd117304;
      6: v = 27'sd58666;
      7: v = 27'sd29335;
      8: v = 27'sd14668;
      9: v = 27'sd7334;
      10: v = 27'sd3667;
      11: v = 27'sd1833;
      12: v = 27'sd917;
      13: v = 27'sd458;
      14: v = 27'sd229;
      15: v = 27'sd115;
      16: v = 27'sd57;
      17: v = 27'sd29;
      18: v = 27'sd14;
      19: v = 27'sd7;
      20: v = 27'sd4;
      21: v = 27'sd2;
      22: v = 27'sd1;
      default: v = 27'sd0;
    endcase
    return v;
  endfunction

  // Count (raw >>> 2) times gravity
  function automatic logic signed [33:0] scale_mul(logic signed [15:0] raw);
    logic signed [33:0] c;
    c = 34'(raw >>> 2);
    return c * GRAVITY_Q16;
  endfunction

  // Round to Q8, ties away from zero; shift depends on the range
  function automatic logic signed [16:0] scale_round(logic signed [33:0] p, logic [1:0] rng);
    logic [33:0] m;
    logic [4:0] s;
    logic [16:0] r;
    m = p[33] ? 34'(-p) : 34'(p);
    s = 5'd20 - 5'(rng);
    m = (m + (34'd1 << (s - 5'd1))) >> s;
    r = m[16:0];
    return p[33] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [31:0] square(logic signed [16:0] v);
    logic signed [33:0] t;
    t = 34'(v) * 34'(v);
    return t[31:0];
  endfunction

  // Q16 degrees to Q8, ties away from zero
  function automatic logic signed [26:0] rnd8(logic signed [26:0] z);
    logic [26:0] m;
    m = z[26] ? 27'(-z) : 27'(z);
    m = (m + 27'd128) >> 8;
    return z[26] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [26:0] clamp(logic signed [26:0] v, logic signed [26:0] lim);
    logic signed [26:0] r;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    else r = v;
    return r;
  endfunction

  // Work done by stage k; n is the CORDIC iteration count
  function automatic item_t stage_next(item_t a, int k, int n, logic [1:0] rng);
    item_t o;
    int j;
    logic [32:0] hs;
    logic [48:0] hb;
    logic [33:0] mb;
    logic [48:0] hf;
    logic signed [26:0] dx;
    logic signed [26:0] dy;
    logic signed [26:0] x0;
    logic signed [26:0] y0;
    logic signed [26:0] zp;
    logic signed [26:0] zr;
    o = a;
    j = 0;
    if (k == ST_MUL) begin
      o.px = scale_mul(a.raw_x);
      o.py = scale_mul(a.raw_y);
      o.pz = scale_mul(a.raw_z);
    end else if (k == ST_ROUND) begin
      o.ax = scale_round(a.px, rng);
      o.ay = scale_round(a.py, rng);
      o.az = scale_round(a.pz, rng);
    end else if (k == ST_SQUARE) begin
      o.sqx = square(a.ax);
      o.sqy = square(a.ay);
      o.sqz = square(a.az);
      // pitch vector (az, ax) in Q16, folded into the right half plane
      x0 = 27'(a.az) <<< 8;
      y0 = 27'(a.ax) <<< 8;
      o.czero = (a.ax == 17'sd0) && (a.az == 17'sd0);
      if (a.az[16]) begin
        o.cz = a.ax[16] ? -Z180 : Z180;
        o.cx = -x0;
        o.cy = -y0;
      end else begin
        o.cz = 27'sd0;
        o.cx = x0;
        o.cy = y0;
      end
    end else if (k == ST_SUM) begin
      hs = 33'(a.sqx) + 33'(a.sqz);
      o.hrem = {hs, 16'd0};
      o.hr = '0;
      o.mrem = 34'(hs) + 34'(a.sqy);
      o.mr = '0;
    end else if (k >= ST_SQRT && k < ST_SQRT + HSQ_ITERS) begin
      j = k - ST_SQRT;
      hb = 49'd1 << (46 - 2 * j);
      if (a.hrem >= a.hr + hb) begin
        o.hrem = a.hrem - (a.hr + hb);
        o.hr = (a.hr >> 1) + hb;
      end else begin
        o.hr = a.hr >> 1;
      end
      if (j < MSQ_ITERS) begin
        mb = 34'd1 << (32 - 2 * j);
        if (a.mrem >= a.mr + mb) begin
          o.mrem = a.mrem - (a.mr + mb);
          o.mr = (a.mr >> 1) + mb;
        end else begin
          o.mr = a.mr >> 1;
        end
      end
      if (j < n) begin
        dx = a.cy >>> j;
        dy = a.cx >>> j;
        if (!a.cy[26]) begin
          o.cx = a.cx + dx;
          o.cy = a.cy - dy;
          o.cz = a.cz + atan_q16(j);
        end else begin
          o.cx = a.cx - dx;
          o.cy = a.cy + dy;
          o.cz = a.cz - atan_q16(j);
        end
      end
    end else if (k == ST_FIN) begin
      // final rounding of both roots, then roll vector (horiz, ay)
      hf = a.hr + 49'(a.hrem > a.hr);
      o.hr = hf;
      o.mr = a.mr + 34'(a.mrem > a.mr);
      o.rx = 27'(hf);
      o.ry = 27'(a.ay) <<< 8;
      o.rz = 27'sd0;
      o.rzero = (hf == 49'd0) && (a.ay == 17'sd0);
    end else if (k >= ST_ROLL && k < ST_ROLL + n) begin
      j = k - ST_ROLL;
      dx = a.ry >>> j;
      dy = a.rx >>> j;
      if (!a.ry[26]) begin
        o.rx = a.rx + dx;
        o.ry = a.ry - dy;
        o.rz = a.rz + atan_q16(j);
      end else begin
        o.rx = a.rx - dx;
        o.ry = a.ry + dy;
        o.rz = a.rz - atan_q16(j);
      end
    end else if (k == ST_ROLL + n) begin
      zp = a.czero ? 27'sd0 : a.cz;
      zr = a.rzero ? 27'sd0 : a.rz;
      zp = clamp(-rnd8(zp), PITCH_LIMIT);
      zr = clamp(rnd8(zr), ROLL_LIMIT);
      o.pitch = zp[16:0];
      o.roll = zr[15:0];
    end
    return o;
  endfunction

endpackage

// ===== rtl/core/ast_stage.sv =====
// One register stage of the scale-and-tilt pipeline with its valid bit.
// Depends on ast_pkg for the item type and the per-stage function.
module ast_stage #(
  parameter int STAGE = 0,
  parameter int CORDIC_STAGES = ast_pkg::CORDIC_STAGES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        range_i,
  input  logic              valid_i,
  input  ast_pkg::item_t    item_i,
  output logic              ready_o,
  output logic              valid_o,
  output ast_pkg::item_t    item_o,
  input  logic              ready_i
);
  import ast_pkg::*;

  logic  valid_q;
  item_t item_q;
  item_t item_d;

  assign item_d = stage_next(item_i, STAGE, CORDIC_STAGES, range_i);

  // Stage takes a transfer when empty or when its content moves on
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o = item_q;
endmodule

// ===== rtl/core/accel_scale_and_tilt.sv =====
// Top level of the accelerometer scale-and-tilt block: register port
// and the stage chain. Depends on ast_pkg and ast_stage.
//
// Usage: raw three-axis samples enter on the s_axis channel, one per
// transfer; each yields one result on m_axis with the three scaled
// accelerations, the magnitude, pitch and roll, all in Q8.
// range_select is written over the APB-style port at address 0; the user
// must write it only while the block is idle, which the block itself does
// not enforce. Reads return it. Throughput: one sample per cycle while
// m_axis_tready is high. The chain holds the 24-step square root of the
// horizontal length followed by the roll CORDIC, one step per stage.
// Reset empties every stage and sets range_select to 8 g.
// When m_axis_tready is low the last stage holds its result; earlier
// stages keep filling empty slots, so the chain absorbs up to its depth
// of samples before s_axis_tready falls. Nothing is dropped or repeated.
module accel_scale_and_tilt #(
  parameter int CORDIC_STAGES = ast_pkg::CORDIC_STAGES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // APB-style configuration
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  // input samples
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [47:0]   s_axis_tdata,  // raw_x, raw_y, raw_z
  // results
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // accel_x, accel_y, accel_z, magnitude, pitch_deg, roll_deg, 3 zero bits
  output logic [103:0]  m_axis_tdata
);
  import ast_pkg::*;

  localparam int NumStages = ST_ROLL + CORDIC_STAGES + 1;

  logic [1:0] range_q;
  logic [1:0] range_d;
  logic       wr_hit;

  logic  valid_s [NumStages+1];
  logic  ready_s [NumStages+1];
  item_t item_s  [NumStages+1];
  item_t in_item;
  item_t out_item;

  // Register port
  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == RegRangeSelect);
  assign range_d = wr_hit ? pwdata[1:0] : range_q;
  assign prdata = (paddr[2] == RegRangeSelect) ? {30'd0, range_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= RangeReset;
    end else begin
      range_q <= range_d;
    end
  end

  // Unpack the input sample
  always_comb begin
    in_item = '0;
    in_item.raw_x = s_axis_tdata[15:0];
    in_item.raw_y = s_axis_tdata[31:16];
    in_item.raw_z = s_axis_tdata[47:32];
  end

  assign valid_s[0] = s_axis_tvalid;
  assign item_s[0] = in_item;
  assign s_axis_tready = ready_s[0];
  assign ready_s[NumStages] = m_axis_tready;

  // Stage chain
  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    ast_stage #(
      .STAGE(k),
      .CORDIC_STAGES(CORDIC_STAGES)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .range_i(range_q),
      .valid_i(valid_s[k]),
      .item_i (item_s[k]),
      .ready_o(ready_s[k]),
      .valid_o(valid_s[k+1]),
      .item_o (item_s[k+1]),
      .ready_i(ready_s[k+1])
    );
  end

  // Pack the result
  assign out_item = item_s[NumStages];
  assign m_axis_tvalid = valid_s[NumStages];
  assign m_axis_tdata = {3'b000, out_item.roll, out_item.pitch, out_item.mr[16:0],
                         out_item.az, out_item.ay, out_item.ax};
endmodule
